>>> hdl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants of the command frame serializer.
// ----------------------------------------------------------------------------
package cfs_pkg;

    // frame constants
    localparam logic [7:0] HDR_BYTE  = 8'h6D;
    localparam logic [7:0] MAN_SIZE  = 8'h0A;
    localparam logic [7:0] MAN_TYPE  = 8'h00;
    localparam logic [7:0] GAIN_SIZE = 8'h0D;
    localparam logic [7:0] GAIN_TYPE = 8'h01;

    localparam int FRAME_BYTES = 16;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    // index of the checksum byte for each frame kind
    localparam logic [IDX_W-1:0] MAN_LAST  = IDX_W'(12);
    localparam logic [IDX_W-1:0] GAIN_LAST = IDX_W'(15);

    // frame kinds
    typedef enum logic {
        OP_MANEUVER = 1'b0,
        OP_GAIN     = 1'b1
    } opcode_t;

    // one fully built frame, checksum included
    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]            last_idx;
    } frame_t;

    // status of the frame queue
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> hdl/cfs_front.sv
// ----------------------------------------------------------------------------
// cfs_front
// Accepts command items, classifies them and builds the complete frame.
// ----------------------------------------------------------------------------
module cfs_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            opcode,
    input  logic [7:0]      status_flags,
    input  logic [15:0]     pitch_cmd,
    input  logic [15:0]     roll_cmd,
    input  logic [15:0]     throttle_cmd,
    input  logic [15:0]     yaw_cmd,
    input  logic [23:0]     pitch_gains,
    input  logic [23:0]     roll_gains,
    input  logic [23:0]     lift_gains,
    input  logic [23:0]     yaw_gains,
    output logic            push,
    output cfs_pkg::frame_t push_frame,
    input  logic            queue_full
);
    import cfs_pkg::*;

    logic   front_valid_reg;
    logic   front_valid_next;
    frame_t frame_reg;
    frame_t frame_next;
    logic [7:0] sum;

    // build the frame body and checksum
    always_comb
    begin
        frame_next = '0;
        frame_next.bytes[0] = HDR_BYTE;
        case (opcode_t'(opcode))
            OP_MANEUVER:
            begin
                frame_next.bytes[1]  = MAN_SIZE;
                frame_next.bytes[2]  = MAN_TYPE;
                frame_next.bytes[3]  = status_flags;
                frame_next.bytes[4]  = pitch_cmd[7:0];
                frame_next.bytes[5]  = pitch_cmd[15:8];
                frame_next.bytes[6]  = roll_cmd[7:0];
                frame_next.bytes[7]  = roll_cmd[15:8];
                frame_next.bytes[8]  = throttle_cmd[7:0];
                frame_next.bytes[9]  = throttle_cmd[15:8];
                frame_next.bytes[10] = yaw_cmd[7:0];
                frame_next.bytes[11] = yaw_cmd[15:8];
                frame_next.last_idx  = MAN_LAST;
            end
            OP_GAIN:
            begin
                frame_next.bytes[1]  = GAIN_SIZE;
                frame_next.bytes[2]  = GAIN_TYPE;
                frame_next.bytes[3]  = pitch_gains[7:0];
                frame_next.bytes[4]  = pitch_gains[15:8];
                frame_next.bytes[5]  = pitch_gains[23:16];
                frame_next.bytes[6]  = roll_gains[7:0];
                frame_next.bytes[7]  = roll_gains[15:8];
                frame_next.bytes[8]  = roll_gains[23:16];
                frame_next.bytes[9]  = lift_gains[7:0];
                frame_next.bytes[10] = lift_gains[15:8];
                frame_next.bytes[11] = lift_gains[23:16];
                frame_next.bytes[12] = yaw_gains[7:0];
                frame_next.bytes[13] = yaw_gains[15:8];
                frame_next.bytes[14] = yaw_gains[23:16];
                frame_next.last_idx  = GAIN_LAST;
            end
            default:
            begin
                frame_next.last_idx = MAN_LAST;
            end
        endcase
        // unused body bytes are zero, so they drop out of the xor
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
        begin
            sum = sum ^ frame_next.bytes[i];
        end
        frame_next.bytes[frame_next.last_idx] = sum;
    end

    // hand-off to the queue
    assign push     = front_valid_reg && !queue_full;
    assign in_stall = front_valid_reg && queue_full;

    assign front_valid_next = in_stall ? front_valid_reg : in_valid;

    // front stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            frame_reg <= frame_next;
        end
    end

    assign push_frame = frame_reg;

endmodule

>>> hdl/cfs_queue.sv
// ----------------------------------------------------------------------------
// cfs_queue
// Two-entry frame queue between the front and the back.
// ----------------------------------------------------------------------------
module cfs_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cfs_pkg::frame_t       push_frame,
    input  logic                  pop,
    output cfs_pkg::frame_t       head_frame,
    output cfs_pkg::queue_status_t status
);
    import cfs_pkg::*;

    frame_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    assign head_frame = entry_reg[rd_ptr_reg];

endmodule

>>> hdl/cfs_back.sv
// ----------------------------------------------------------------------------
// cfs_back
// Walks the frame at the queue head one byte per transfer into the output
// register, and retires the frame after its checksum byte.
// ----------------------------------------------------------------------------
module cfs_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfs_pkg::frame_t        head_frame,
    input  cfs_pkg::queue_status_t qstat,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             frame_byte,
    output logic                   last_byte
);
    import cfs_pkg::*;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             last_reg;
    logic             last_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             load;
    logic             at_last;

    assign load    = !out_valid_reg || !out_stall;
    assign at_last = (idx_reg == head_frame.last_idx);
    assign pop     = load && !qstat.empty && at_last;

    // next output byte and position in the frame
    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = !qstat.empty;
            if (!qstat.empty)
            begin
                byte_next = head_frame.bytes[idx_reg];
                last_next = at_last;
                idx_next  = at_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

endmodule

>>> hdl/command_frame_serializer.sv
// ----------------------------------------------------------------------------
// command_frame_serializer
// Packs a command item into a checksummed serial frame, one byte per transfer.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with the command fields; opcode 0
//   sends a 13-byte maneuver frame, opcode 1 a 16-byte gain frame
//   output channel: out_valid / out_stall with frame_byte and last_byte;
//   last_byte marks the checksum byte that closes each frame
//   path: after the input transfer the frame passes the front register,
//   then a queue entry, and its header byte then the output register
//   throughput: one output byte per cycle while the receiver does not stall;
//   the back end's byte counter sets this, and queued frames follow each
//   other with no gap
//   the front holds one frame and the queue two more, so input transfers
//   keep being taken while earlier frames are still streaming out
//   reset: all valid flags and the queue clear, no frame is in flight
//   receiver stall: the output byte holds, the back end stops, the queue
//   fills and in_stall rises once the front cannot hand off its frame
// ----------------------------------------------------------------------------
module command_frame_serializer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  status_flags,
    input  logic [15:0] pitch_cmd,
    input  logic [15:0] roll_cmd,
    input  logic [15:0] throttle_cmd,
    input  logic [15:0] yaw_cmd,
    input  logic [23:0] pitch_gains,
    input  logic [23:0] roll_gains,
    input  logic [23:0] lift_gains,
    input  logic [23:0] yaw_gains,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);
    import cfs_pkg::*;

    logic          push;
    logic          pop;
    frame_t        push_frame;
    frame_t        head_frame;
    queue_status_t qstat;

    // classify and build frames
    cfs_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .status_flags (status_flags),
        .pitch_cmd    (pitch_cmd),
        .roll_cmd     (roll_cmd),
        .throttle_cmd (throttle_cmd),
        .yaw_cmd      (yaw_cmd),
        .pitch_gains  (pitch_gains),
        .roll_gains   (roll_gains),
        .lift_gains   (lift_gains),
        .yaw_gains    (yaw_gains),
        .push         (push),
        .push_frame   (push_frame),
        .queue_full   (qstat.full)
    );

    // decoupling queue
    cfs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_frame (head_frame),
        .status     (qstat)
    );

    // byte serializer
    cfs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_frame (head_frame),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

    // queue cannot be full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
    else $error("frame queue full and empty at once");

    // input only stalls on a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> qstat.full)
    else $error("input stalled with room in the queue");

    // a frame streams without gaps until its checksum byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_byte) |=> out_valid)
    else $error("gap inside a frame");

    // a pop only happens with a byte leaving for the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && last_byte))
    else $error("frame retired without its checksum byte");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for command_frame_serializer: drives maneuver and gain
// commands, rebuilds each frame with its XOR checksum on the side, and
// compares every output byte and its last-byte flag in order.
// ----------------------------------------------------------------------------
module tb;
    import cfs_pkg::*;

    localparam int RANDOM_COMMANDS = 270;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 32;

    // one command as presented on the input channel
    typedef struct {
        opcode_t     op;
        logic [7:0]  status;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [15:0] throttle;
        logic [15:0] yaw;
        logic [23:0] pitch_g;
        logic [23:0] roll_g;
        logic [23:0] lift_g;
        logic [23:0] yaw_g;
    } command_t;

    // expected frame bytes, oldest first
    class frame_scoreboard;
        typedef struct {
            logic [7:0] data;
            logic       last;
        } frame_slot_t;

        frame_slot_t expected_bytes[$];
        int          errors;
        int          maneuver_frames;
        int          gain_frames;
        int          bytes_checked;

        function void note_command(command_t c);
            logic [7:0]  frame[$];
            logic [7:0]  sum;
            frame_slot_t slot;
            frame.push_back(HDR_BYTE);
            if (c.op == OP_MANEUVER)
            begin
                frame.push_back(MAN_SIZE);
                frame.push_back(MAN_TYPE);
                frame.push_back(c.status);
                frame.push_back(c.pitch[7:0]);
                frame.push_back(c.pitch[15:8]);
                frame.push_back(c.roll[7:0]);
                frame.push_back(c.roll[15:8]);
                frame.push_back(c.throttle[7:0]);
                frame.push_back(c.throttle[15:8]);
                frame.push_back(c.yaw[7:0]);
                frame.push_back(c.yaw[15:8]);
                maneuver_frames++;
            end
            else
            begin
                frame.push_back(GAIN_SIZE);
                frame.push_back(GAIN_TYPE);
                for (int k = 0; k < 3; k++) frame.push_back(c.pitch_g[8*k +: 8]);
                for (int k = 0; k < 3; k++) frame.push_back(c.roll_g[8*k +: 8]);
                for (int k = 0; k < 3; k++) frame.push_back(c.lift_g[8*k +: 8]);
                for (int k = 0; k < 3; k++) frame.push_back(c.yaw_g[8*k +: 8]);
                gain_frames++;
            end
            // checksum covers every earlier byte
            sum = 8'h00;
            foreach (frame[k]) sum ^= frame[k];
            frame.push_back(sum);
            foreach (frame[k])
            begin
                slot.data = frame[k];
                slot.last = (k == frame.size() - 1);
                expected_bytes.push_back(slot);
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            frame_slot_t want;
            bytes_checked++;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, got %02h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data)
            begin
                $display("%0t: frame_byte mismatch: expected %02h, got %02h",
                         $time, want.data, data);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_byte mismatch: expected %0b, got %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending_count();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [7:0]  status_flags;
    logic [15:0] pitch_cmd;
    logic [15:0] roll_cmd;
    logic [15:0] throttle_cmd;
    logic [15:0] yaw_cmd;
    logic [23:0] pitch_gains;
    logic [23:0] roll_gains;
    logic [23:0] lift_gains;
    logic [23:0] yaw_gains;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  frame_byte;
    logic        last_byte;

    frame_scoreboard frames_sb;
    int              accepted_commands;
    int              cycle_count;
    bit              quiet;
    bit              hold_off_done;

    command_frame_serializer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .status_flags (status_flags),
        .pitch_cmd    (pitch_cmd),
        .roll_cmd     (roll_cmd),
        .throttle_cmd (throttle_cmd),
        .yaw_cmd      (yaw_cmd),
        .pitch_gains  (pitch_gains),
        .roll_gains   (roll_gains),
        .lift_gains   (lift_gains),
        .yaw_gains    (yaw_gains),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long, zero in quiet stretches
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic command_t build_command(opcode_t op, logic [7:0] status,
                                               logic [15:0] p, logic [15:0] r,
                                               logic [15:0] t, logic [15:0] y,
                                               logic [23:0] pg, logic [23:0] rg,
                                               logic [23:0] lg, logic [23:0] yg);
        command_t c;
        c.op       = op;
        c.status   = status;
        c.pitch    = p;
        c.roll     = r;
        c.throttle = t;
        c.yaw      = y;
        c.pitch_g  = pg;
        c.roll_g   = rg;
        c.lift_g   = lg;
        c.yaw_g    = yg;
        return c;
    endfunction

    function automatic command_t random_command();
        return build_command($urandom_range(0, 1) ? OP_GAIN : OP_MANEUVER,
                             8'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 24'($urandom),
                             24'($urandom), 24'($urandom), 24'($urandom));
    endfunction

    // present one command and hold it until the transfer
    task automatic send_command(input command_t c);
        opcode       <= c.op;
        status_flags <= c.status;
        pitch_cmd    <= c.pitch;
        roll_cmd     <= c.roll;
        throttle_cmd <= c.throttle;
        yaw_cmd      <= c.yaw;
        pitch_gains  <= c.pitch_g;
        roll_gains   <= c.roll_g;
        lift_gains   <= c.lift_g;
        yaw_gains    <= c.yaw_g;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_with_gap(input command_t c);
        int gap;
        send_command(c);
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // input transfers feed the predictor, output transfers get checked
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            frames_sb.note_command(build_command(opcode_t'(opcode), status_flags,
                                                 pitch_cmd, roll_cmd, throttle_cmd,
                                                 yaw_cmd, pitch_gains, roll_gains,
                                                 lift_gains, yaw_gains));
            accepted_commands++;
        end
        if (rst_n && out_valid && !out_stall)
            frames_sb.check_byte(frame_byte, last_byte);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, frames_sb.pending_count());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off while the sender keeps going
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int n;
            if (!hold_off_done && accepted_commands >= 40)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            n = idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // sender and end of run
    initial
    begin
        frames_sb    = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_MANEUVER;
        status_flags = '0;
        pitch_cmd    = '0;
        roll_cmd     = '0;
        throttle_cmd = '0;
        yaw_cmd      = '0;
        pitch_gains  = '0;
        roll_gains   = '0;
        lift_gains   = '0;
        yaw_gains    = '0;
        quiet        = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, both frame kinds, back to back
        send_with_gap(build_command(OP_MANEUVER, 8'h00, 16'h0000, 16'h0000,
                                    16'h0000, 16'h0000, '0, '0, '0, '0));
        send_with_gap(build_command(OP_MANEUVER, 8'hFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF, '0, '0, '0, '0));
        send_with_gap(build_command(OP_GAIN, 8'h00, 16'h0000, 16'h0000,
                                    16'h0000, 16'h0000, '0, '0, '0, '0));
        send_with_gap(build_command(OP_GAIN, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                                    16'h0000, 24'hFFFFFF, 24'hFFFFFF,
                                    24'hFFFFFF, 24'hFFFFFF));
        // unused fields set: they must not leak into the frame
        send_with_gap(build_command(OP_MANEUVER, 8'hA5, 16'h1234, 16'h5678,
                                    16'h9ABC, 16'hDEF0, 24'hFFFFFF, 24'hFFFFFF,
                                    24'hFFFFFF, 24'hFFFFFF));
        send_with_gap(build_command(OP_GAIN, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 24'h030201, 24'h060504,
                                    24'h090807, 24'h0C0B0A));
        // alternating bit patterns and byte order checks
        send_with_gap(build_command(OP_MANEUVER, 8'h55, 16'hAA55, 16'h55AA,
                                    16'h00FF, 16'hFF00, '0, '0, '0, '0));
        send_with_gap(build_command(OP_GAIN, 8'h00, '0, '0, '0, '0, 24'hAA55AA,
                                    24'h55AA55, 24'h0000FF, 24'hFF0000));
        // payload that cancels the header bytes in the checksum
        send_with_gap(build_command(OP_MANEUVER, 8'h67, 16'h0000, 16'h0000,
                                    16'h0000, 16'h0000, '0, '0, '0, '0));
        send_with_gap(build_command(OP_GAIN, 8'h00, '0, '0, '0, '0, 24'h000061,
                                    24'h000000, 24'h000000, 24'h000000));

        // random commands, idling switched on and off in stretches
        for (int i = 0; i < RANDOM_COMMANDS; i++)
        begin
            if (i % 20 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send_with_gap(random_command());
        end
        in_valid <= 1'b0;

        while (frames_sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d maneuver and %0d gain frames, %0d bytes checked,",
                 frames_sb.maneuver_frames, frames_sb.gain_frames,
                 frames_sb.bytes_checked);
        $display("with random stalls on both sides and one long receiver hold-off");
        if (frames_sb.errors == 0 && frames_sb.pending_count() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/cfs_pkg.sv
hdl/cfs_front.sv
hdl/cfs_queue.sv
hdl/cfs_back.sv
hdl/command_frame_serializer.sv
dv/tb.sv
